@@ rtl/clsu_pkg.sv @@
// Package for the load/store unit: item types, result codes and packing widths.
// No dependencies.
package clsu_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE       = 3'd0,
    KIND_READ        = 3'd1,
    KIND_COMPLETE    = 3'd2,
    KIND_UNSUPPORTED = 3'd3,
    KIND_ORDER       = 3'd4
  } kind_e;

  localparam logic [7:0] HIGH_PAGE = 8'hFF;

  // classified instruction item
  typedef struct packed {
    logic        is_data;
    logic [7:0]  opcode;
    logic [15:0] immediate;
    logic [7:0]  read_data;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        last;
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
  } result_t;

endpackage

@@ rtl/clsu_front.sv @@
// Front end of the load/store unit: accepts stream items into a short queue.
// Depends on clsu_pkg.
module clsu_front import clsu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t            mem_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign in_ready_o = (cnt_q != (AW+1)'(Depth));
  assign q_valid_o  = (cnt_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ rtl/clsu_back.sv @@
// Back end of the load/store unit: register file and execution of one item.
// Depends on clsu_pkg; fed by clsu_front, drives a one-entry output skid.
module clsu_back import clsu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  output logic    q_pop_o,
  input  item_t   q_item_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);
  logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q, pop_op_q, first_q;
  logic [3:0]  f_q;
  logic [15:0] sp_q;
  logic        wait_q, second_q, phase_q;
  logic        ov_q;
  result_t     res_q;

  logic [7:0]  a_d, b_d, c_d, d_d, e_d, h_d, l_d, pop_op_d, first_d, i8, src_v, hi, lo;
  logic [3:0]  f_d;
  logic [15:0] sp_d, hl, imm, addr0, addr1;
  logic        wait_d, second_d, two, fire;
  logic [2:0]  kind;
  logic [7:0]  wd0, wd1, op;
  logic [8:0]  csum;
  logic [4:0]  hsum;

  function automatic logic [7:0] sel_r(input logic [2:0] i, input logic [7:0] a,
      input logic [7:0] b, input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
      input logic [7:0] h, input logic [7:0] l);
    logic [7:0] r;
    unique case (i)
      3'd0: r = b; 3'd1: r = c; 3'd2: r = d; 3'd3: r = e;
      3'd4: r = h; 3'd5: r = l; 3'd7: r = a;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign hl  = {h_q, l_q};
  assign op  = q_item_i.opcode;
  assign imm = q_item_i.immediate;
  assign i8  = imm[7:0];
  assign src_v = sel_r(op[2:0], a_q, b_q, c_q, d_q, e_q, h_q, l_q);
  assign csum = {1'b0, sp_q[7:0]} + {1'b0, i8};
  assign hsum = {1'b0, sp_q[3:0]} + {1'b0, i8[3:0]};

  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    f_d = f_q; sp_d = sp_q; pop_op_d = pop_op_q; first_d = first_q;
    wait_d = wait_q; second_d = second_q;
    kind = KIND_COMPLETE; addr0 = '0; addr1 = '0; wd0 = '0; wd1 = '0; two = 1'b0;
    hi = '0; lo = '0;
    if (q_item_i.is_data != wait_q) begin
      kind = KIND_ORDER;
    end else if (q_item_i.is_data) begin
      if ((pop_op_q & 8'hCF) == 8'hC1) begin
        if (!second_q) begin
          first_d = q_item_i.read_data; second_d = 1'b1;
          kind = KIND_READ; addr0 = sp_q + 16'd1;
        end else begin
          unique case (pop_op_q[5:4])
            2'd0: begin b_d = q_item_i.read_data; c_d = first_q; end
            2'd1: begin d_d = q_item_i.read_data; e_d = first_q; end
            2'd2: begin h_d = q_item_i.read_data; l_d = first_q; end
            default: begin a_d = q_item_i.read_data; f_d = first_q[7:4]; end
          endcase
          sp_d = sp_q + 16'd2; wait_d = 1'b0; second_d = 1'b0;
        end
      end else if (pop_op_q[7:6] == 2'b01) begin
        unique case (pop_op_q[5:3])
          3'd0: b_d = q_item_i.read_data; 3'd1: c_d = q_item_i.read_data;
          3'd2: d_d = q_item_i.read_data; 3'd3: e_d = q_item_i.read_data;
          3'd4: h_d = q_item_i.read_data; 3'd5: l_d = q_item_i.read_data;
          3'd7: a_d = q_item_i.read_data;
          default: ;
        endcase
        wait_d = 1'b0; second_d = 1'b0;
      end else begin
        a_d = q_item_i.read_data;
        if (pop_op_q == 8'h2A) {h_d, l_d} = hl + 16'd1;
        if (pop_op_q == 8'h3A) {h_d, l_d} = hl - 16'd1;
        wait_d = 1'b0; second_d = 1'b0;
      end
    end else begin
      kind = KIND_COMPLETE;
      priority case (1'b1)
        op == 8'h02: begin kind = KIND_WRITE; addr0 = {b_q, c_q}; wd0 = a_q; end
        op == 8'h12: begin kind = KIND_WRITE; addr0 = {d_q, e_q}; wd0 = a_q; end
        op == 8'h22: begin kind = KIND_WRITE; addr0 = hl; wd0 = a_q; {h_d, l_d} = hl + 16'd1; end
        op == 8'h32: begin kind = KIND_WRITE; addr0 = hl; wd0 = a_q; {h_d, l_d} = hl - 16'd1; end
        op == 8'h36: begin kind = KIND_WRITE; addr0 = hl; wd0 = i8; end
        op == 8'hE0: begin kind = KIND_WRITE; addr0 = {HIGH_PAGE, i8}; wd0 = a_q; end
        op == 8'hE2: begin kind = KIND_WRITE; addr0 = {HIGH_PAGE, c_q}; wd0 = a_q; end
        op == 8'hEA: begin kind = KIND_WRITE; addr0 = imm; wd0 = a_q; end
        op == 8'h0A: begin kind = KIND_READ; addr0 = {b_q, c_q}; end
        op == 8'h1A: begin kind = KIND_READ; addr0 = {d_q, e_q}; end
        op == 8'h2A || op == 8'h3A: begin kind = KIND_READ; addr0 = hl; end
        op == 8'hF0: begin kind = KIND_READ; addr0 = {HIGH_PAGE, i8}; end
        op == 8'hF2: begin kind = KIND_READ; addr0 = {HIGH_PAGE, c_q}; end
        op == 8'hFA: begin kind = KIND_READ; addr0 = imm; end
        (op & 8'hCF) == 8'hC1: begin kind = KIND_READ; addr0 = sp_q; end
        (op & 8'hC7) == 8'h06 && op != 8'h36: begin
          unique case (op[5:3])
            3'd0: b_d = i8; 3'd1: c_d = i8; 3'd2: d_d = i8; 3'd3: e_d = i8;
            3'd4: h_d = i8; 3'd5: l_d = i8; default: a_d = i8;
          endcase
        end
        op == 8'h01: {b_d, c_d} = imm;
        op == 8'h11: {d_d, e_d} = imm;
        op == 8'h21: {h_d, l_d} = imm;
        op == 8'h31: sp_d = imm;
        op == 8'hF9: sp_d = hl;
        op == 8'hF8: begin
          {h_d, l_d} = sp_q + {{8{i8[7]}}, i8};
          f_d = {2'b00, hsum[4], csum[8]};
        end
        op == 8'h08: begin
          kind = KIND_WRITE; two = 1'b1; addr0 = imm; wd0 = sp_q[7:0];
          addr1 = imm + 16'd1; wd1 = sp_q[15:8];
        end
        (op & 8'hCF) == 8'hC5: begin
          unique case (op[5:4])
            2'd0: begin hi = b_q; lo = c_q; end
            2'd1: begin hi = d_q; lo = e_q; end
            2'd2: begin hi = h_q; lo = l_q; end
            default: begin hi = a_q; lo = {f_q, 4'h0}; end
          endcase
          kind = KIND_WRITE; two = 1'b1; addr0 = sp_q - 16'd1; wd0 = hi;
          addr1 = sp_q - 16'd2; wd1 = lo; sp_d = sp_q - 16'd2;
        end
        op[7:6] == 2'b01 && op != 8'h76: begin
          if (op[2:0] == 3'd6) begin
            kind = KIND_READ; addr0 = hl;
          end else if (op[5:3] == 3'd6) begin
            kind = KIND_WRITE; addr0 = hl; wd0 = src_v;
          end else begin
            unique case (op[5:3])
              3'd0: b_d = src_v; 3'd1: c_d = src_v; 3'd2: d_d = src_v; 3'd3: e_d = src_v;
              3'd4: h_d = src_v; 3'd5: l_d = src_v; default: a_d = src_v;
            endcase
          end
        end
        default: kind = KIND_UNSUPPORTED;
      endcase
      if (kind == KIND_READ) begin
        wait_d = 1'b1; second_d = 1'b0; pop_op_d = op;
      end
    end
  end

  // one item retires per free output slot; a two-result item takes two slots
  assign fire    = q_valid_i && (!ov_q || out_ready_i);
  assign q_pop_o = fire && (!two || phase_q);
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.kind  <= kind;
      res_q.addr  <= phase_q ? addr1 : addr0;
      res_q.wdata <= phase_q ? wd1 : wd0;
      res_q.last  <= !two || phase_q;
      res_q.af    <= {a_d, f_d, 4'h0};
      res_q.bc    <= {b_d, c_d};
      res_q.de    <= {d_d, e_d};
      res_q.hl    <= {h_d, l_d};
      res_q.sp    <= sp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
      f_q <= '0; sp_q <= '0; pop_op_q <= '0; first_q <= '0;
      wait_q <= 1'b0; second_q <= 1'b0; phase_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (fire) begin
        ov_q <= 1'b1;
        if (two && !phase_q) begin
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
          h_q <= h_d; l_q <= l_d; f_q <= f_d; sp_q <= sp_d;
          pop_op_q <= pop_op_d; first_q <= first_d;
          wait_q <= wait_d; second_q <= second_d;
        end
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end
endmodule

@@ rtl/cpu_load_store_unit.sv @@
// Top level of the load/store unit: input queue front end and execute back end.
// Depends on clsu_pkg, clsu_front and clsu_back.
//
// Usage: items enter on the s_axis group, one per transfer. tuser carries
// req_type (0 instruction, 1 read data); tdata carries opcode, immediate and
// read_data. Results leave on m_axis: tdata holds access_kind, mem_address,
// mem_write_data and the five register pairs after the step; tlast marks the
// final result of an input item.
// Path: an accepted item is written into the queue at the accepting edge, and the
// execute stage then registers its result in the output register.
// Throughput: one result per cycle while m_axis_tready is high, so one item per
// cycle, except PUSH and LD (a16),SP which give two results, one after the other.
// Reset clears the CPU registers to zero, empties the queue and drops any result.
// When m_axis_tready is low the output register holds its result; the queue
// keeps accepting until its QueueDepth entries (two by default) are full, then s_axis_tready drops.
module cpu_load_store_unit import clsu_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // opcode[7:0], immediate[23:8], read_data[31:24]
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [111:0] m_axis_tdata, // access_kind[2:0], mem_address[18:3],
                                     // mem_write_data[26:19], reg_af[42:27], reg_bc[58:43],
                                     // reg_de[74:59], reg_hl[90:75], reg_sp[106:91]
  output logic        m_axis_tlast
);
  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  assign in_item.is_data   = s_axis_tuser;
  assign in_item.opcode    = s_axis_tdata[7:0];
  assign in_item.immediate = s_axis_tdata[23:8];
  assign in_item.read_data = s_axis_tdata[31:24];

  clsu_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  clsu_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {5'b0, res.sp, res.hl, res.de, res.bc, res.af,
                         res.wdata, res.addr, res.kind};
  assign m_axis_tlast = res.last;
endmodule

@@ tb/sv/cpu_load_store_unit_test.sv @@
// Testbench for cpu_load_store_unit: drives instruction and read-data items on the
// input stream, predicts every result and compares it on the output stream.
// Depends on clsu_pkg and the cpu_load_store_unit RTL.
`timescale 1ns / 100ps

module cpu_load_store_unit_test;
  import clsu_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        last;
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] sp;
  } access_t;

  localparam int unsigned CycleLimit = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;

  cpu_load_store_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #10 clk_i = ~clk_i;

  // predicted CPU state
  logic [7:0]  cpu_a, cpu_b, cpu_c, cpu_d, cpu_e, cpu_h, cpu_l;
  logic [3:0]  cpu_flags;
  logic [15:0] cpu_sp;
  logic [7:0]  wait_op;
  logic        read_busy, pop_high;
  logic [7:0]  pop_low;

  access_t     expected_accesses[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  bit          recv_hold = 1'b0;

  function automatic logic [7:0] reg_by_code(logic [2:0] code);
    case (code)
      3'd0: return cpu_b;
      3'd1: return cpu_c;
      3'd2: return cpu_d;
      3'd3: return cpu_e;
      3'd4: return cpu_h;
      3'd5: return cpu_l;
      3'd7: return cpu_a;
      default: return 8'h00;
    endcase
  endfunction

  task automatic set_reg_by_code(logic [2:0] code, logic [7:0] v);
    case (code)
      3'd0: cpu_b = v;
      3'd1: cpu_c = v;
      3'd2: cpu_d = v;
      3'd3: cpu_e = v;
      3'd4: cpu_h = v;
      3'd5: cpu_l = v;
      3'd7: cpu_a = v;
      default: ;
    endcase
  endtask

  task automatic push_access(kind_e kind, logic [15:0] addr, logic [7:0] wdata, logic last);
    access_t r;
    r.kind = kind;
    r.addr = addr;
    r.wdata = wdata;
    r.last = last;
    r.af = {cpu_a, cpu_flags, 4'h0};
    r.bc = {cpu_b, cpu_c};
    r.de = {cpu_d, cpu_e};
    r.hl = {cpu_h, cpu_l};
    r.sp = cpu_sp;
    expected_accesses.push_back(r);
  endtask

  task automatic issue_read(logic [7:0] op, logic [15:0] addr);
    read_busy = 1'b1;
    pop_high = 1'b0;
    wait_op = op;
    push_access(KIND_READ, addr, 8'h00, 1'b1);
  endtask

  task automatic execute_item(logic is_data, logic [7:0] op, logic [15:0] imm,
                              logic [7:0] rd);
    logic [15:0] hl, sp0, ext;
    logic [7:0]  i8, hi, lo;
    logic        hc, cc;
    hl = {cpu_h, cpu_l};
    i8 = imm[7:0];
    if (is_data != read_busy) begin
      push_access(KIND_ORDER, 16'h0, 8'h00, 1'b1);
      return;
    end
    if (is_data) begin
      if ((wait_op & 8'hCF) == 8'hC1) begin
        if (!pop_high) begin
          pop_low = rd;
          pop_high = 1'b1;
          push_access(KIND_READ, cpu_sp + 16'd1, 8'h00, 1'b1);
          return;
        end
        case (wait_op[5:4])
          2'd0: {cpu_b, cpu_c} = {rd, pop_low};
          2'd1: {cpu_d, cpu_e} = {rd, pop_low};
          2'd2: {cpu_h, cpu_l} = {rd, pop_low};
          default: begin
            cpu_a = rd;
            cpu_flags = pop_low[7:4];
          end
        endcase
        cpu_sp = cpu_sp + 16'd2;
      end else if (wait_op >= 8'h40 && wait_op <= 8'h7F) begin
        set_reg_by_code(wait_op[5:3], rd);
      end else begin
        cpu_a = rd;
        if (wait_op == 8'h2A) {cpu_h, cpu_l} = hl + 16'd1;
        if (wait_op == 8'h3A) {cpu_h, cpu_l} = hl - 16'd1;
      end
      read_busy = 1'b0;
      pop_high = 1'b0;
      push_access(KIND_COMPLETE, 16'h0, 8'h00, 1'b1);
      return;
    end
    case (op)
      8'h02: push_access(KIND_WRITE, {cpu_b, cpu_c}, cpu_a, 1'b1);
      8'h12: push_access(KIND_WRITE, {cpu_d, cpu_e}, cpu_a, 1'b1);
      8'h22: begin
        {cpu_h, cpu_l} = hl + 16'd1;
        push_access(KIND_WRITE, hl, cpu_a, 1'b1);
      end
      8'h32: begin
        {cpu_h, cpu_l} = hl - 16'd1;
        push_access(KIND_WRITE, hl, cpu_a, 1'b1);
      end
      8'h36: push_access(KIND_WRITE, hl, i8, 1'b1);
      8'hE0: push_access(KIND_WRITE, {HIGH_PAGE, i8}, cpu_a, 1'b1);
      8'hE2: push_access(KIND_WRITE, {HIGH_PAGE, cpu_c}, cpu_a, 1'b1);
      8'hEA: push_access(KIND_WRITE, imm, cpu_a, 1'b1);
      8'h0A: issue_read(op, {cpu_b, cpu_c});
      8'h1A: issue_read(op, {cpu_d, cpu_e});
      8'h2A, 8'h3A: issue_read(op, hl);
      8'hF0: issue_read(op, {HIGH_PAGE, i8});
      8'hF2: issue_read(op, {HIGH_PAGE, cpu_c});
      8'hFA: issue_read(op, imm);
      8'hC1, 8'hD1, 8'hE1, 8'hF1: issue_read(op, cpu_sp);
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h3E: begin
        set_reg_by_code(op[5:3], i8);
        push_access(KIND_COMPLETE, 16'h0, 8'h00, 1'b1);
      end
      8'h01, 8'h11, 8'h21, 8'h31, 8'hF9, 8'hF8: begin
        case (op)
          8'h01: {cpu_b, cpu_c} = imm;
          8'h11: {cpu_d, cpu_e} = imm;
          8'h21: {cpu_h, cpu_l} = imm;
          8'h31: cpu_sp = imm;
          8'hF9: cpu_sp = hl;
          default: begin
            ext = {{8{i8[7]}}, i8};
            hc = ({1'b0, cpu_sp[3:0]} + {1'b0, i8[3:0]}) > 5'h0F;
            cc = ({1'b0, cpu_sp[7:0]} + {1'b0, i8}) > 9'h0FF;
            {cpu_h, cpu_l} = cpu_sp + ext;
            cpu_flags = {2'b00, hc, cc};
          end
        endcase
        push_access(KIND_COMPLETE, 16'h0, 8'h00, 1'b1);
      end
      8'h08: begin
        push_access(KIND_WRITE, imm, cpu_sp[7:0], 1'b0);
        push_access(KIND_WRITE, imm + 16'd1, cpu_sp[15:8], 1'b1);
      end
      8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
        sp0 = cpu_sp;
        case (op[5:4])
          2'd0: {hi, lo} = {cpu_b, cpu_c};
          2'd1: {hi, lo} = {cpu_d, cpu_e};
          2'd2: {hi, lo} = {cpu_h, cpu_l};
          default: {hi, lo} = {cpu_a, cpu_flags, 4'h0};
        endcase
        cpu_sp = sp0 - 16'd2;
        push_access(KIND_WRITE, sp0 - 16'd1, hi, 1'b0);
        push_access(KIND_WRITE, sp0 - 16'd2, lo, 1'b1);
      end
      default: begin
        if (op >= 8'h40 && op <= 8'h7F && op != 8'h76) begin
          if (op[2:0] == 3'd6) issue_read(op, hl);
          else if (op[5:3] == 3'd6) push_access(KIND_WRITE, hl, reg_by_code(op[2:0]), 1'b1);
          else begin
            set_reg_by_code(op[5:3], reg_by_code(op[2:0]));
            push_access(KIND_COMPLETE, 16'h0, 8'h00, 1'b1);
          end
        end else begin
          push_access(KIND_UNSUPPORTED, 16'h0, 8'h00, 1'b1);
        end
      end
    endcase
  endtask

  // one transfer on the input stream, with an optional random gap before it
  task automatic send_item(logic is_data, logic [7:0] op, logic [15:0] imm, logic [7:0] rd);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= is_data;
    s_axis_tdata <= {rd, imm, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    execute_item(is_data, op, imm, rd);
  endtask

  task automatic send_instr(logic [7:0] op, logic [15:0] imm);
    send_item(1'b0, op, imm, 8'($urandom));
  endtask

  task automatic send_data(logic [7:0] rd);
    send_item(1'b1, 8'($urandom), 16'($urandom), rd);
  endtask

  // answer every read the last instruction started
  task automatic answer_reads();
    while (read_busy) send_data(8'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_accesses.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_opcode();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 8'($urandom);
      1, 2, 3: return 8'($urandom_range(8'h40, 8'h7F));
      4: return {2'b11, 2'($urandom), 4'h1};
      5: return {2'b11, 2'($urandom), 4'h5};
      default: begin
        case ($urandom_range(0, 15))
          0: return 8'h02;
          1: return 8'h12;
          2: return 8'h22;
          3: return 8'h32;
          4: return 8'h36;
          5: return 8'hE0;
          6: return 8'hE2;
          7: return 8'hEA;
          8: return 8'h0A;
          9: return 8'h1A;
          10: return $urandom_range(0, 1) ? 8'h2A : 8'h3A;
          11: return $urandom_range(0, 1) ? 8'hF0 : 8'hF2;
          12: return 8'hFA;
          13: return {2'b00, 3'($urandom), 3'b110};
          14: return {2'b00, 2'($urandom), 4'h1};
          default: return $urandom_range(0, 2) == 0 ? 8'h08 :
                          ($urandom_range(0, 1) ? 8'hF8 : 8'hF9);
        endcase
      end
    endcase
  endfunction

  task automatic test_directed();
    send_data(8'h12);
    send_instr(8'h01, 16'hFFFF);
    send_instr(8'h11, 16'h0000);
    send_instr(8'h21, 16'h00FF);
    send_instr(8'h31, 16'h0000);
    send_instr(8'h3E, 16'h00FF);
    send_instr(8'hF5, 16'h0);
    send_instr(8'h08, 16'hFFFF);
    send_instr(8'h31, 16'h0FFF);
    send_instr(8'hF8, 16'h0081);
    send_instr(8'hF8, 16'h007F);
    send_instr(8'h22, 16'h0);
    send_instr(8'h32, 16'h0);
    send_instr(8'hE0, 16'h0080);
    send_instr(8'hE2, 16'h0);
    send_instr(8'hEA, 16'hA55A);
    send_instr(8'hF1, 16'h0);
    send_instr(8'h00, 16'h0);
    send_data(8'hFF);
    send_data(8'hAB);
    send_instr(8'h76, 16'h0);
    send_instr(8'h2A, 16'h0);
    send_instr(8'h3A, 16'h0);
    send_data(8'h00);
    send_instr(8'hF9, 16'h0);
    send_instr(8'hFA, 16'hFFFF);
    answer_reads();
    drain();
  endtask

  task automatic test_random_programs(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(1'($urandom), 8'($urandom), 16'($urandom),
                                                8'($urandom));
      else begin
        send_instr(pick_opcode(), 16'($urandom));
        if (read_busy && $urandom_range(0, 9) != 0) answer_reads();
      end
    end
    answer_reads();
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    for (int unsigned i = 0; i < 40; i++) begin
      send_instr(pick_opcode(), 16'($urandom));
      answer_reads();
    end
    drain();
  endtask

  // receiver: random stalls, or a long hold-off while recv_hold is set
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (recv_hold) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each transfer with the oldest prediction
  always @(posedge clk_i) begin
    access_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tdata[2:0];
      got.addr = m_axis_tdata[18:3];
      got.wdata = m_axis_tdata[26:19];
      got.last = m_axis_tlast;
      got.af = m_axis_tdata[42:27];
      got.bc = m_axis_tdata[58:43];
      got.de = m_axis_tdata[74:59];
      got.hl = m_axis_tdata[90:75];
      got.sp = m_axis_tdata[106:91];
      if (expected_accesses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transfer: %h", got);
      end else begin
        want = expected_accesses.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    {cpu_a, cpu_b, cpu_c, cpu_d, cpu_e, cpu_h, cpu_l} = '0;
    cpu_flags = '0;
    cpu_sp = '0;
    wait_op = '0;
    read_busy = 1'b0;
    pop_high = 1'b0;
    pop_low = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_programs(550);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random_programs(170);
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_accesses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
